@@ hdl/hes_pkg.sv @@
// Shared types, widths, register codes and constant tables for the harmonic epicycle synth.
// Used by every module of the block; no dependencies of its own.
`default_nettype none

package hes_pkg;

   localparam int HARMONIC_LIMIT    = 100;
   localparam int SINE_TABLE_DEPTH  = 1024;

   localparam int KEPT        = (HARMONIC_LIMIT + 1) / 2;
   localparam int IDX_W       = (KEPT > 1) ? $clog2(KEPT) : 1;
   localparam int N_W         = IDX_W + 1;
   localparam int SINE_ADDR_W = $clog2(SINE_TABLE_DEPTH);
   localparam int LANES       = 2;

   localparam int AMP_W      = 10;
   localparam int PHASE_W    = 32;
   localparam int ORG_W      = 12;
   localparam int POS_W      = 22;
   localparam int TRIG_W     = 16;
   localparam int CSR_INDEX_W = 2;
   localparam int CSR_DATA_W  = 32;

   localparam int ORIGIN_FRAC = 8;
   localparam int ROUND_SHIFT = 7;
   localparam int MAG_W       = AMP_W + TRIG_W - 1;
   localparam int QUOT_W      = MAG_W + 1 - ROUND_SHIFT;
   localparam int CONTRIB_W   = QUOT_W + 1;
   localparam int RECIP_SHIFT = QUOT_W + N_W;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = QUOT_W + RECIP_W;
   localparam int ACC_W       = POS_W + 3;

   localparam logic [PHASE_W-1:0] QUARTER_TURN = PHASE_W'(1) << (PHASE_W - 2);
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;

   localparam logic [AMP_W-1:0]   AMP_RESET   = AMP_W'(100);
   localparam logic [PHASE_W-1:0] STEP_RESET  = PHASE_W'(71582788);
   localparam logic [ORG_W-1:0]   ORG_X_RESET = ORG_W'(200);
   localparam logic [ORG_W-1:0]   ORG_Y_RESET = ORG_W'(700);

   localparam logic signed [POS_W-1:0] POS_MAX = {1'b0, {(POS_W-1){1'b1}}};
   localparam logic signed [POS_W-1:0] POS_MIN = {1'b1, {(POS_W-1){1'b0}}};
   localparam logic signed [ACC_W-1:0] ACC_POS_MAX = ACC_W'(POS_MAX);
   localparam logic signed [ACC_W-1:0] ACC_POS_MIN = ACC_W'(POS_MIN);

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_BASE_AMPLITUDE = 2'd0,
      CSR_PHASE_STEP     = 2'd1,
      CSR_ORIGIN_X       = 2'd2,
      CSR_ORIGIN_Y       = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             valid;
      logic             last;
      logic [IDX_W-1:0] idx;
   } slot_type;

   typedef logic signed [TRIG_W-1:0] sine_table_type [SINE_TABLE_DEPTH];
   typedef logic [RECIP_W-1:0] recip_table_type [KEPT];

   // sin((m/D)*pi/2) in Q15 by a truncated Q30 Taylor series
   function automatic logic signed [TRIG_W-1:0] quarter_sine(input logic [31:0] m);
      logic [63:0]        x;
      logic [63:0]        x2;
      logic [63:0]        term;
      logic signed [63:0] sum;
      x    = (64'(m) * HALF_PI_Q30) / 64'(SINE_TABLE_DEPTH);
      x2   = (x * x) >> 30;
      term = x;
      sum  = signed'(x);
      for (int j = 1; j < 10; j++) begin
         term = (term * x2) >> 30;
         term = term / 64'((2 * j) * (2 * j + 1));
         if (j[0]) begin
            sum = sum - signed'(term);
         end else begin
            sum = sum + signed'(term);
         end
      end
      if (sum < 0) begin
         sum = 0;
      end
      sum = (sum + 64'sd16384) >>> 15;
      if (sum > 64'sd32767) begin
         sum = 64'sd32767;
      end
      return TRIG_W'(sum);
   endfunction

   function automatic sine_table_type build_sine_table();
      sine_table_type           tab;
      logic [31:0]              q;
      logic [31:0]              m;
      logic signed [TRIG_W-1:0] v;
      for (int k = 0; k < SINE_TABLE_DEPTH; k++) begin
         q = 32'((4 * k) / SINE_TABLE_DEPTH);
         m = 32'(4 * k) - q * 32'(SINE_TABLE_DEPTH);
         v = q[0] ? quarter_sine(32'(SINE_TABLE_DEPTH) - m) : quarter_sine(m);
         tab[k] = q[1] ? -v : v;
      end
      return tab;
   endfunction

   // long division by shift and subtract, used when building tables
   function automatic logic [63:0] table_div(input logic [63:0] a, input logic [63:0] b);
      logic [63:0] rem;
      logic [63:0] quo;
      rem = '0;
      quo = '0;
      for (int i = 63; i >= 0; i--) begin
         rem = {rem[62:0], a[i]};
         if (rem >= b) begin
            rem    = rem - b;
            quo[i] = 1'b1;
         end
      end
      return quo;
   endfunction

   // ceil(2^RECIP_SHIFT / n) for each kept harmonic n = 2i+1
   function automatic recip_table_type build_recip_table();
      recip_table_type tab;
      logic [63:0]     n;
      for (int i = 0; i < KEPT; i++) begin
         n = 64'(2 * i + 1);
         tab[i] = RECIP_W'(table_div((64'd1 << RECIP_SHIFT) + n - 64'd1, n));
      end
      return tab;
   endfunction

   localparam sine_table_type  SINE_TABLE  = build_sine_table();
   localparam recip_table_type RECIP_TABLE = build_recip_table();

endpackage

`default_nettype wire

@@ hdl/hes_phase_ram.sv @@
// Harmonic phase memory: one write and one registered read port, per-entry written flags.
// Depends on hes_pkg; an entry never written since reset reads as zero.
`default_nettype none

module hes_phase_ram (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [hes_pkg::IDX_W-1:0]   rd_addr,
   output logic [hes_pkg::PHASE_W-1:0] rd_data,
   input  logic                        wr_en,
   input  logic [hes_pkg::IDX_W-1:0]   wr_addr,
   input  logic [hes_pkg::PHASE_W-1:0] wr_data
);
   import hes_pkg::*;

   logic [PHASE_W-1:0] mem [KEPT];
   logic [KEPT-1:0]    written_ff;
   logic [PHASE_W-1:0] rd_data_ff;
   logic               rd_written_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         written_ff    <= '0;
         rd_written_ff <= 1'b0;
      end else begin
         rd_written_ff <= written_ff[rd_addr];
         if (wr_en) begin
            written_ff[wr_addr] <= 1'b1;
         end
      end
   end

   assign rd_data = rd_written_ff ? rd_data_ff : '0;

endmodule

`default_nettype wire

@@ hdl/hes_sine_rom.sv @@
// Dual-read sine ROM with registered outputs, one read for sine and one for cosine.
// Depends on hes_pkg for the table contents.
`default_nettype none

module hes_sine_rom (
   input  logic                                clock,
   input  logic [hes_pkg::SINE_ADDR_W-1:0]     sin_addr,
   input  logic [hes_pkg::SINE_ADDR_W-1:0]     cos_addr,
   output logic signed [hes_pkg::TRIG_W-1:0]   sin_data,
   output logic signed [hes_pkg::TRIG_W-1:0]   cos_data
);
   import hes_pkg::*;

   logic signed [TRIG_W-1:0] sin_data_ff;
   logic signed [TRIG_W-1:0] cos_data_ff;

   always_ff @(posedge clock) begin
      sin_data_ff <= SINE_TABLE[sin_addr];
      cos_data_ff <= SINE_TABLE[cos_addr];
   end

   assign sin_data = sin_data_ff;
   assign cos_data = cos_data_ff;

endmodule

`default_nettype wire

@@ hdl/hes_term_unit.sv @@
// Four-stage term pipeline: scale by amplitude, divide by 128n with rounding, apply sign.
// Depends on hes_pkg; x and y lanes share the harmonic tag and reciprocal lookup.
`default_nettype none

module hes_term_unit (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic [hes_pkg::AMP_W-1:0]            amp,
   input  hes_pkg::slot_type                    slot_in,
   input  logic signed [hes_pkg::TRIG_W-1:0]    trig_x,
   input  logic signed [hes_pkg::TRIG_W-1:0]    trig_y,
   output hes_pkg::slot_type                    slot_out,
   output logic signed [hes_pkg::CONTRIB_W-1:0] contrib_x,
   output logic signed [hes_pkg::CONTRIB_W-1:0] contrib_y
);
   import hes_pkg::*;

   slot_type slot1_ff;
   slot_type slot2_ff;
   slot_type slot3_ff;
   slot_type slot4_ff;

   logic signed [TRIG_W-1:0]    trig       [LANES];
   logic [TRIG_W-1:0]           trig_abs   [LANES];
   logic [AMP_W+TRIG_W-1:0]     mag_full   [LANES];
   logic [MAG_W:0]              num        [LANES];
   logic [QUOT_W-1:0]           quot       [LANES];
   logic [MAG_W-1:0]            mag_ff     [LANES];
   logic [QUOT_W-1:0]           dividend_ff[LANES];
   logic [PROD_W-1:0]           prod_ff    [LANES];
   logic signed [CONTRIB_W-1:0] contrib_ff [LANES];
   logic [LANES-1:0]            neg1_ff;
   logic [LANES-1:0]            neg2_ff;
   logic [LANES-1:0]            neg3_ff;
   logic [RECIP_W-1:0]          recip_ff;
   logic [N_W-1:0]              n1;
   logic [MAG_W:0]              half_den;

   assign trig[0] = trig_x;
   assign trig[1] = trig_y;
   assign n1       = {slot1_ff.idx, 1'b1};
   assign half_den = (MAG_W+1)'({n1, {(ROUND_SHIFT-1){1'b0}}});

   always_comb begin
      for (int l = 0; l < LANES; l++) begin
         trig_abs[l] = trig[l][TRIG_W-1] ? TRIG_W'(-trig[l]) : TRIG_W'(trig[l]);
         mag_full[l] = (AMP_W+TRIG_W)'(amp) * (AMP_W+TRIG_W)'(trig_abs[l]);
         num[l]      = {1'b0, mag_ff[l]} + half_den;
         quot[l]     = prod_ff[l][RECIP_SHIFT +: QUOT_W];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot1_ff <= '0;
         slot2_ff <= '0;
         slot3_ff <= '0;
         slot4_ff <= '0;
      end else begin
         slot1_ff <= slot_in;
         slot2_ff <= slot1_ff;
         slot3_ff <= slot2_ff;
         slot4_ff <= slot3_ff;
      end
   end

   always_ff @(posedge clock) begin
      recip_ff <= RECIP_TABLE[slot1_ff.idx];
      for (int l = 0; l < LANES; l++) begin
         mag_ff[l]      <= mag_full[l][MAG_W-1:0];
         neg1_ff[l]     <= trig[l][TRIG_W-1] ^ slot_in.idx[0];
         dividend_ff[l] <= num[l][MAG_W:ROUND_SHIFT];
         neg2_ff[l]     <= neg1_ff[l];
         prod_ff[l]     <= PROD_W'(dividend_ff[l]) * PROD_W'(recip_ff);
         neg3_ff[l]     <= neg2_ff[l];
         contrib_ff[l]  <= neg3_ff[l] ? -signed'({1'b0, quot[l]}) : signed'({1'b0, quot[l]});
      end
   end

   assign slot_out  = slot4_ff;
   assign contrib_x = contrib_ff[0];
   assign contrib_y = contrib_ff[1];

endmodule

`default_nettype wire

@@ hdl/harmonic_epicycle_synth_top.sv @@
// Harmonic epicycle synth: odd-harmonic square-wave Fourier sum traced as an epicycle endpoint.
// A new req word is taken only once the previous result is loaded; the phase memory serves one harmonic per cycle.
// The phase memory read, sine ROM and four-stage term pipeline sit behind that sweep.
// Reset (synchronous): registers to defaults, phase written flags cleared so all phases read 0.
// Depends on hes_pkg, hes_phase_ram, hes_sine_rom and hes_term_unit.
`default_nettype none

module harmonic_epicycle_synth_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic                                req_tick,
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic signed [hes_pkg::POS_W-1:0]    rsp_x_pos,
   output logic signed [hes_pkg::POS_W-1:0]    rsp_y_pos,
   input  logic                                csr_wr_en,
   input  logic [hes_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  logic [hes_pkg::CSR_DATA_W-1:0]      csr_wr_data
);
   import hes_pkg::*;

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_ISSUE = 3'b010,
      S_DRAIN = 3'b100
   } state_type;

   state_type              state_ff, state_in;
   logic [IDX_W-1:0]       issue_idx_ff, issue_idx_in;
   logic                   tick_ff;
   logic [AMP_W-1:0]       amp_ff;
   logic [PHASE_W-1:0]     step_ff;
   logic [ORG_W-1:0]       org_x_ff;
   logic [ORG_W-1:0]       org_y_ff;
   logic [PHASE_W-1:0]     inc_ff;
   slot_type               slot_a;
   slot_type               slot_b_ff;
   slot_type               slot_c_ff;
   slot_type               slot_t;
   logic signed [ACC_W-1:0] acc_x_ff;
   logic signed [ACC_W-1:0] acc_y_ff;
   logic                   sum_done_ff;
   logic                   rsp_valid_ff;
   logic signed [POS_W-1:0] rsp_x_ff;
   logic signed [POS_W-1:0] rsp_y_ff;

   logic                   req_fire;
   logic                   issue_last;
   logic                   out_free;
   logic                   load;
   logic [PHASE_W-1:0]     phase_cur;
   logic [PHASE_W-1:0]     phase_new;
   logic [PHASE_W-1:0]     phase_cos;
   logic signed [TRIG_W-1:0]    sin_data;
   logic signed [TRIG_W-1:0]    cos_data;
   logic signed [CONTRIB_W-1:0] contrib_x;
   logic signed [CONTRIB_W-1:0] contrib_y;

   function automatic logic signed [POS_W-1:0] clamp_pos(input logic signed [ACC_W-1:0] v);
      if (v > ACC_POS_MAX) begin
         return POS_MAX;
      end else if (v < ACC_POS_MIN) begin
         return POS_MIN;
      end
      return v[POS_W-1:0];
   endfunction

   assign req_stall  = (state_ff != S_IDLE);
   assign req_fire   = req_valid && !req_stall;
   assign issue_last = (issue_idx_ff == IDX_W'(KEPT - 1));
   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign load       = (state_ff == S_DRAIN) && sum_done_ff && out_free;

   always_comb begin
      state_in     = state_ff;
      issue_idx_in = issue_idx_ff;
      case (state_ff)
         S_IDLE: begin
            issue_idx_in = '0;
            if (req_fire) begin
               state_in = S_ISSUE;
            end
         end
         S_ISSUE: begin
            if (issue_last) begin
               state_in = S_DRAIN;
            end else begin
               issue_idx_in = issue_idx_ff + IDX_W'(1);
            end
         end
         S_DRAIN: begin
            if (load) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         issue_idx_ff <= '0;
      end else begin
         state_ff     <= state_in;
         issue_idx_ff <= issue_idx_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         amp_ff   <= AMP_RESET;
         step_ff  <= STEP_RESET;
         org_x_ff <= ORG_X_RESET;
         org_y_ff <= ORG_Y_RESET;
      end else if (csr_wr_en) begin
         case (csr_index)
            CSR_BASE_AMPLITUDE: amp_ff   <= csr_wr_data[AMP_W-1:0];
            CSR_PHASE_STEP:     step_ff  <= csr_wr_data[PHASE_W-1:0];
            CSR_ORIGIN_X:       org_x_ff <= csr_wr_data[ORG_W-1:0];
            CSR_ORIGIN_Y:       org_y_ff <= csr_wr_data[ORG_W-1:0];
            default: ;
         endcase
      end
   end

   // issue, read-modify-write, ROM stages
   assign slot_a.valid = (state_ff == S_ISSUE);
   assign slot_a.last  = issue_last;
   assign slot_a.idx   = issue_idx_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_b_ff <= '0;
         slot_c_ff <= '0;
      end else begin
         slot_b_ff <= slot_a;
         slot_c_ff <= slot_b_ff;
      end
   end

   // hold n * phase_step for the harmonic in the write-back stage
   always_ff @(posedge clock) begin
      if (req_fire) begin
         tick_ff <= req_tick;
         inc_ff  <= step_ff;
      end else if (slot_b_ff.valid) begin
         inc_ff  <= inc_ff + {step_ff[PHASE_W-2:0], 1'b0};
      end
   end

   assign phase_new = phase_cur + (tick_ff ? inc_ff : '0);
   assign phase_cos = phase_new + QUARTER_TURN;

   hes_phase_ram u_phase_ram (
      .clock   (clock),
      .reset   (reset),
      .rd_addr (issue_idx_ff),
      .rd_data (phase_cur),
      .wr_en   (slot_b_ff.valid),
      .wr_addr (slot_b_ff.idx),
      .wr_data (phase_new)
   );

   hes_sine_rom u_sine_rom (
      .clock    (clock),
      .sin_addr (phase_new[PHASE_W-1 -: SINE_ADDR_W]),
      .cos_addr (phase_cos[PHASE_W-1 -: SINE_ADDR_W]),
      .sin_data (sin_data),
      .cos_data (cos_data)
   );

   hes_term_unit u_term_unit (
      .clock     (clock),
      .reset     (reset),
      .amp       (amp_ff),
      .slot_in   (slot_c_ff),
      .trig_x    (cos_data),
      .trig_y    (sin_data),
      .slot_out  (slot_t),
      .contrib_x (contrib_x),
      .contrib_y (contrib_y)
   );

   // accumulate
   always_ff @(posedge clock) begin
      if (req_fire) begin
         acc_x_ff <= {{(ACC_W-ORG_W-ORIGIN_FRAC){1'b0}}, org_x_ff, {ORIGIN_FRAC{1'b0}}};
         acc_y_ff <= {{(ACC_W-ORG_W-ORIGIN_FRAC){1'b0}}, org_y_ff, {ORIGIN_FRAC{1'b0}}};
      end else if (slot_t.valid) begin
         acc_x_ff <= acc_x_ff + ACC_W'(contrib_x);
         acc_y_ff <= acc_y_ff + ACC_W'(contrib_y);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_done_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (load) begin
            sum_done_ff <= 1'b0;
         end else if (slot_t.valid && slot_t.last) begin
            sum_done_ff <= 1'b1;
         end
         if (load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         rsp_x_ff <= clamp_pos(acc_x_ff);
         rsp_y_ff <= clamp_pos(acc_y_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_x_pos = rsp_x_ff;
   assign rsp_y_pos = rsp_y_ff;

endmodule

`default_nettype wire

@@ hdl/hes_checker.sv @@
// Port-level checks for harmonic_epicycle_synth_top, attached by the bind below.
// Depends on hes_pkg for widths.
`default_nettype none

module hes_checker (
   input logic                                clock,
   input logic                                reset,
   input logic                                req_valid,
   input logic                                req_stall,
   input logic                                rsp_valid,
   input logic                                rsp_stall,
   input logic signed [hes_pkg::POS_W-1:0]    rsp_x_pos,
   input logic signed [hes_pkg::POS_W-1:0]    rsp_y_pos
);
   import hes_pkg::*;

   a_reset_ready: assert property (@(posedge clock) reset |=> !req_stall && !rsp_valid)
      else $error("block not idle after reset");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("second word taken while a word is in work");

   a_word_ends_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !req_stall)
      else $error("result shown while the sweep is still busy");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_x_pos) && $stable(rsp_y_pos))
      else $error("stalled rsp word changed or dropped");

endmodule

bind harmonic_epicycle_synth_top hes_checker u_hes_checker (.*);

`default_nettype wire
